/* design/spq_pkg.sv */
// Shared types and codes for the sorted-array priority queue.
// Used by spq_cell and sorted_array_priority_queue_top; no dependencies.
package spq_pkg;

   localparam int KEY_W     = 16;
   localparam int PAYLOAD_W = 32;
   localparam int FILL_W    = 7;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_REMOVE = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_INSERTED = 2'd0,
      ST_FULL     = 2'd1,
      ST_REMOVED  = 2'd2,
      ST_EMPTY    = 2'd3
   } status_type;

   typedef struct packed {
      logic                 valid;
      logic [KEY_W-1:0]     key;
      logic [PAYLOAD_W-1:0] payload;
   } entry_type;

   typedef struct packed {
      logic                 push;
      logic                 pop;
      logic [KEY_W-1:0]     key;
      logic [PAYLOAD_W-1:0] payload;
   } cmd_type;

endpackage

/* design/sorted_array_priority_queue_top.sv */
// Sorted-array max-priority queue built as a chain of spq_cell slots, largest key in slot 0.
// The result is registered and is valid in the cycle after the request is accepted. One request per cycle
// while no result waits or rsp_tready is high, as the whole cell chain shifts at once; a held result drops req_tready.
// Reset clears the slot valid bits, the count and the result valid bit; no clearing pass.
// Depends on spq_pkg and spq_cell.
module sorted_array_priority_queue_top #(
   parameter int CAPACITY = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // key[15:0], payload[47:16]
   input  logic [0:0]  req_tuser,   // operation[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // out_key[15:0], out_payload[47:16], fill_count[54:48], zero pad
   output logic [1:0]  rsp_tuser    // status[1:0]
);
   import spq_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);

   entry_type            entries [CAPACITY];
   logic                 gts     [CAPACITY];
   cmd_type              cmd;

   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           status_ff, status_in;
   logic [KEY_W-1:0]     out_key_ff, out_key_in;
   logic [PAYLOAD_W-1:0] out_payload_ff, out_payload_in;
   logic [FILL_W-1:0]    fill_ff, fill_in;

   logic                 accept, full, empty;
   op_type               op;
   logic [CNT_W+FILL_W-1:0] count_ext;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign op         = op_type'(req_tuser[0]);
   assign full       = (count_ff == CNT_W'(CAPACITY));
   assign empty      = (count_ff == '0);

   assign cmd.push    = accept && (op == OP_INSERT) && !full;
   assign cmd.pop     = accept && (op == OP_REMOVE) && !empty;
   assign cmd.key     = req_tdata[15:0];
   assign cmd.payload = req_tdata[47:16];

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      entry_type prev_e, next_e;
      logic      prev_g;
      if (i == 0) begin : g_first
         assign prev_g = 1'b1;
         assign prev_e = '0;
      end else begin : g_mid
         assign prev_g = gts[i-1];
         assign prev_e = entries[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign next_e = '0;
      end else begin : g_rest
         assign next_e = entries[i+1];
      end
      spq_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .prev_gt    (prev_g),
         .prev_entry (prev_e),
         .next_entry (next_e),
         .entry      (entries[i]),
         .gt         (gts[i])
      );
   end

   always_comb begin
      count_in       = count_ff;
      status_in      = status_ff;
      out_key_in     = out_key_ff;
      out_payload_in = out_payload_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      if (cmd.push) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.pop) begin
         count_in = count_ff - CNT_W'(1);
      end
      if (accept) begin
         rsp_valid_in   = 1'b1;
         out_key_in     = '0;
         out_payload_in = '0;
         if (op == OP_INSERT) begin
            status_in = full ? ST_FULL : ST_INSERTED;
         end else if (empty) begin
            status_in = ST_EMPTY;
         end else begin
            status_in      = ST_REMOVED;
            out_key_in     = entries[0].key;
            out_payload_in = entries[0].payload;
         end
      end
      count_ext = {{FILL_W{1'b0}}, count_in};
      fill_in   = accept ? count_ext[FILL_W-1:0] : fill_ff;
   end

   always_ff @(posedge clock) begin
      status_ff      <= status_in;
      out_key_ff     <= out_key_in;
      out_payload_ff <= out_payload_in;
      fill_ff        <= fill_in;
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = status_ff;
   assign rsp_tdata  = {1'b0, fill_ff, out_payload_ff, out_key_ff};

endmodule

/* design/spq_cell.sv */
// One slot of the sorted chain: holds an entry, compares it with the broadcast key
// and trades entries with its neighbors. Depends on spq_pkg.
module spq_cell (
   input  logic              clock,
   input  logic              reset,
   input  spq_pkg::cmd_type  cmd,
   input  logic              prev_gt,
   input  spq_pkg::entry_type prev_entry,
   input  spq_pkg::entry_type next_entry,
   output spq_pkg::entry_type entry,
   output logic              gt
);
   import spq_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;

   assign gt    = entry_ff.valid && (entry_ff.key > cmd.key);
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (cmd.push) begin
         if (gt) begin
            entry_in = entry_ff;
         end else if (prev_gt) begin
            entry_in.valid   = 1'b1;
            entry_in.key     = cmd.key;
            entry_in.payload = cmd.payload;
         end else begin
            entry_in = prev_entry;
         end
      end else if (cmd.pop) begin
         entry_in = next_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff.key     <= entry_in.key;
      entry_ff.payload <= entry_in.payload;
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else begin
         entry_ff.valid <= entry_in.valid;
      end
   end

endmodule
